[rtl/core/hidkbd_pkg.sv]
package hidkbd_pkg;

    // held-key store and report geometry
    localparam int KEY_STORE    = 16;
    localparam int REPORT_SLOTS = 6;
    localparam int OUT_SLOTS    = 6;
    localparam int IDX_W        = $clog2(KEY_STORE);
    localparam int CNT_W        = $clog2(KEY_STORE + 1);
    localparam int SLOT_W       = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

    localparam logic [7:0] ROLLOVER_CODE = 8'h01;
    localparam logic [7:0] NO_KEY        = 8'h00;

    typedef enum logic [0:0] {
        OP_KEY_EVENT   = 1'b0,
        OP_RELEASE_ALL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] usage_code;
        logic [7:0] modifier_mask;
        logic       is_pressed;
    } t_in_item;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_out_item;

endpackage

[rtl/core/hid_boot_keyboard_report_core.sv]
// usb hid boot keyboard report builder. each input item is either a key event
// (loads the modifier byte and, for a nonzero usage code, presses or releases
// that key) or a release-all. held keys live in a KEY_STORE-entry synchronous
// ram in press order; a key event scans the held entries one per cycle
// (the ram read is registered, and a closing step makes the decision), then
// either appends the code or, on a release, compacts the list by reading
// entry j and writing it back at j-1, again one entry per cycle. the first
// REPORT_SLOTS entries are mirrored in slot registers during both passes so
// the report needs no extra read pass. a zero usage code or release-all
// skips both passes, and a release moves only the entries after its key up.
// a finished report waits until the output register is free. the rate is
// set by the single read port of the key ram. one item is in flight at a
// time; the result sits in an output register, so the next item is taken
// while the previous report still waits. release-all with no modifier set
// and no key held produces no report. with more than REPORT_SLOTS keys held
// every slot reads 0x01 (rollover); presses beyond KEY_STORE held keys are
// dropped.
module hid_boot_keyboard_report_core
    import hidkbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_mod, n_mod;
    logic [7:0]       r_code, n_code;
    logic             r_press, n_press;
    logic [CNT_W-1:0] r_idx, n_idx;     // next entry to read
    logic             r_pend, n_pend;   // read data valid this cycle
    logic [IDX_W-1:0] r_pidx, n_pidx;   // entry of the pending read data
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_pos, n_pos;     // where the code was found
    logic             r_out_valid;

    // key ram and payload
    logic [7:0]       r_mem [KEY_STORE];
    logic [7:0]       r_rd_data;
    logic [7:0]       r_slot [REPORT_SLOTS];
    t_out_item        r_out;

    // datapath controls
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             slot_we;
    logic [SLOT_W-1:0] slot_idx;
    logic [7:0]       slot_data;
    logic             out_load;
    logic             in_fire;
    logic             rollover;
    logic [7:0]       slot_val [OUT_SLOTS];
    logic [IDX_W-1:0] prev_idx;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign prev_idx   = r_pidx - IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_mod       <= '0;
            r_code      <= '0;
            r_press     <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pidx      <= '0;
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mod   <= n_mod;
            r_code  <= n_code;
            r_press <= n_press;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_pidx  <= n_pidx;
            r_found <= n_found;
            r_pos   <= n_pos;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_mod     = r_mod;
        n_code    = r_code;
        n_press   = r_press;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_pos     = r_pos;
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = r_code;
        rd_en     = 1'b0;
        rd_addr   = r_idx[IDX_W-1:0];
        slot_we   = 1'b0;
        slot_idx  = SLOT_W'(r_pidx);
        slot_data = r_rd_data;
        out_load  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_item.op == OP_RELEASE_ALL) begin
                        // nothing held and no modifiers: no report
                        if (r_mod != '0 || r_count != '0) begin
                            n_mod   = '0;
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_mod = i_in_item.modifier_mask;
                        if (i_in_item.usage_code == NO_KEY) begin
                            n_state = ST_DONE;
                        end else begin
                            n_code  = i_in_item.usage_code;
                            n_press = i_in_item.is_pressed;
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_pos   = '0;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    // mirror the report slots while scanning
                    if (CNT_W'(r_pidx) < CNT_W'(REPORT_SLOTS)) begin
                        slot_we = 1'b1;
                    end
                    if (r_rd_data == r_code && !r_found) begin
                        n_found = 1'b1;
                        n_pos   = r_pidx;
                    end
                end
                if (r_idx >= r_count && !r_pend) begin
                    if (r_press) begin
                        if (!r_found && r_count < CNT_W'(KEY_STORE)) begin
                            mem_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            if (r_count < CNT_W'(REPORT_SLOTS)) begin
                                slot_we   = 1'b1;
                                slot_idx  = SLOT_W'(r_count);
                                slot_data = r_code;
                            end
                        end
                        n_state = ST_DONE;
                    end else if (r_found) begin
                        n_idx   = CNT_W'(r_pos) + CNT_W'(1);
                        n_state = ST_COMPACT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_COMPACT: begin
                if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    // move entry up one place
                    mem_we    = 1'b1;
                    mem_waddr = prev_idx;
                    mem_wdata = r_rd_data;
                    if (CNT_W'(prev_idx) < CNT_W'(REPORT_SLOTS)) begin
                        slot_we  = 1'b1;
                        slot_idx = SLOT_W'(prev_idx);
                    end
                end
                if (r_idx >= r_count && !r_pend) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // key ram, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot[slot_idx] <= slot_data;
        end
    end

    // report assembly
    assign rollover = (r_count > CNT_W'(REPORT_SLOTS));

    always_comb begin
        for (int i = 0; i < OUT_SLOTS; i++) begin
            slot_val[i] = NO_KEY;
            if (i < REPORT_SLOTS) begin
                if (rollover) begin
                    slot_val[i] = ROLLOVER_CODE;
                end else if (CNT_W'(i) < r_count) begin
                    slot_val[i] = r_slot[SLOT_W'(i)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.modifiers  <= r_mod;
            r_out.key_slot_0 <= slot_val[0];
            r_out.key_slot_1 <= slot_val[1];
            r_out.key_slot_2 <= slot_val[2];
            r_out.key_slot_3 <= slot_val[3];
            r_out.key_slot_4 <= slot_val[4];
            r_out.key_slot_5 <= slot_val[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // held count never exceeds the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(KEY_STORE))
        else $error("held count beyond key store");

    // release-all leaves nothing held
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.op == OP_RELEASE_ALL) |=> (r_count == '0 && r_mod == '0))
        else $error("release-all did not clear state");

    // pending read data only inside a ram pass
    a_pend_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN || r_state == ST_COMPACT))
        else $error("read data pending outside scan or compact");

    // compaction writes only below the last held entry
    a_compact_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == ST_COMPACT) |-> (CNT_W'(mem_waddr) + CNT_W'(1) < r_count))
        else $error("compaction write out of range");

    // a report is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_item))
        else $error("pending report overwritten");

endmodule

[dv/hid_boot_keyboard_report_core_test.sv]
module hid_boot_keyboard_report_core_test;

    import hidkbd_pkg::*;

    // idle cycles with no handshake on either side before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES = 300;
    // quiet tail after the last report, longer than the slowest item
    localparam int TAIL_CYCLES = 2 * KEY_STORE + 10;
    localparam int REPORT_BYTES = 1 + OUT_SLOTS;

    // tracks the held-key list and modifier byte, queues the reports the block owes
    class keyboard_report_tracker;
        logic [7:0]  held_codes [KEY_STORE];
        int unsigned held_total;
        logic [7:0]  modifier_byte;
        t_out_item   reports_due [$];
        int unsigned mismatches;
        string       field_names [REPORT_BYTES] = '{"modifiers", "key_slot_0", "key_slot_1",
                                                    "key_slot_2", "key_slot_3", "key_slot_4",
                                                    "key_slot_5"};

        function new();
            held_total    = 0;
            modifier_byte = 8'h00;
            mismatches    = 0;
            foreach (held_codes[k]) held_codes[k] = NO_KEY;
        endfunction

        function void note_input(t_in_item it);
            logic [7:0] slot_val [OUT_SLOTS];
            bit         found;
            int         pos;
            bit         rollover;
            t_out_item  rpt;
            if (it.op == OP_RELEASE_ALL) begin
                // nothing to clear, nothing reported
                if (modifier_byte == 8'h00 && held_total == 0) return;
                modifier_byte = 8'h00;
                held_total    = 0;
            end else begin
                modifier_byte = it.modifier_mask;
                if (it.usage_code != NO_KEY) begin
                    found = 1'b0;
                    pos   = 0;
                    for (int k = 0; k < held_total; k++) begin
                        if (!found && held_codes[k] == it.usage_code) begin
                            found = 1'b1;
                            pos   = k;
                        end
                    end
                    if (it.is_pressed) begin
                        // new key goes to the tail unless the store is full
                        if (!found && held_total < KEY_STORE) begin
                            held_codes[held_total] = it.usage_code;
                            held_total++;
                        end
                    end else if (found) begin
                        // close the gap, keep press order
                        for (int k = pos; k + 1 < held_total; k++)
                            held_codes[k] = held_codes[k + 1];
                        held_total--;
                    end
                end
            end
            rollover = held_total > REPORT_SLOTS;
            for (int k = 0; k < OUT_SLOTS; k++) begin
                slot_val[k] = NO_KEY;
                if (k < REPORT_SLOTS) begin
                    if (rollover) slot_val[k] = ROLLOVER_CODE;
                    else if (k < held_total) slot_val[k] = held_codes[k];
                end
            end
            rpt = {modifier_byte, slot_val[0], slot_val[1], slot_val[2],
                   slot_val[3], slot_val[4], slot_val[5]};
            reports_due = {reports_due, rpt};
        endfunction

        function void check_report(t_out_item got);
            t_out_item  want;
            logic [7:0] want_byte;
            logic [7:0] got_byte;
            if (reports_due.size() == 0) begin
                $error("report %h arrived with none due", got);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            for (int f = 0; f < REPORT_BYTES; f++) begin
                want_byte = want[$bits(t_out_item) - 1 - 8 * f -: 8];
                got_byte  = got[$bits(t_out_item) - 1 - 8 * f -: 8];
                if (got_byte !== want_byte) begin
                    $error("%s: expected %h, got %h", field_names[f], want_byte, got_byte);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // raised by the stimulus, cleared by the receiver once its hold-off is done
    bit hold_req       = 1'b0;

    keyboard_report_tracker tracker;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    hid_boot_keyboard_report_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // offer one item, hold it until the block takes it, then log it with the tracker
    task automatic offer_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_input(it);
    endtask

    task automatic key_event(input logic [7:0] code, input logic [7:0] mods, input bit pressed);
        t_in_item it;
        it.op            = OP_KEY_EVENT;
        it.usage_code    = code;
        it.modifier_mask = mods;
        it.is_pressed    = pressed;
        offer_item(it);
    endtask

    task automatic release_all();
        t_in_item it;
        it.op            = OP_RELEASE_ALL;
        it.usage_code    = 8'($urandom);
        it.modifier_mask = 8'($urandom);
        it.is_pressed    = 1'($urandom);
        offer_item(it);
    endtask

    // random typing: mostly presses and releases from a small pool of keys so the
    // held list grows into rollover and a full store, plus noise codes
    task automatic random_typing(input int items, input int idle_pct, input int stall_pct);
        logic [7:0] pool [24];
        int         pool_n;
        int         roll;
        t_in_item   it;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pool_n = $urandom_range(6, 24);
        for (int k = 0; k < 24; k++) pool[k] = 8'($urandom_range(1, 255));
        repeat (items) begin
            roll             = $urandom_range(0, 99);
            it.op            = (roll < 4) ? OP_RELEASE_ALL : OP_KEY_EVENT;
            it.modifier_mask = 8'($urandom);
            it.is_pressed    = ($urandom_range(0, 99) < 60);
            if (roll < 14) it.usage_code = NO_KEY;
            else if (roll < 28) it.usage_code = 8'($urandom_range(0, 255));
            else it.usage_code = pool[$urandom_range(0, pool_n - 1)];
            offer_item(it);
        end
    endtask

    // report sink, sampled at the same edge the handshake completes
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) tracker.check_report(out_item);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // hang detector: any accepted item on either side restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // release-all right after reset: nothing held, no report
        release_all();
        // zero usage code only loads the modifiers
        key_event(NO_KEY, 8'hFF, 1'b1);
        // release-all with only modifiers set still reports
        release_all();
        // fill the store, passing through rollover at the seventh key;
        // includes the top code and a code equal to the rollover marker
        for (int k = 0; k < KEY_STORE; k++)
            key_event((k == 0) ? 8'hFF : (k == 1) ? 8'h01 : 8'(8'h03 + k), 8'(k * 17), 1'b1);
        // store full: new press dropped
        key_event(8'h80, 8'hA5, 1'b1);
        // repeated press of a held key
        key_event(8'hFF, 8'h5A, 1'b1);
        // release of a key that is not held
        key_event(8'h90, 8'h00, 1'b0);
        // release of the oldest key, longest compaction
        key_event(8'hFF, 8'h81, 1'b0);
        // release from the middle of the list
        key_event(8'h0A, 8'h42, 1'b0);
        // release with a zero usage code
        key_event(NO_KEY, 8'h18, 1'b0);
        // release-all with keys held, then again with nothing left
        release_all();
        release_all();

        random_typing(150, 0, 0);
        random_typing(150, 67, 0);
        random_typing(150, 0, 67);
        random_typing(150, 26, 26);

        // back-pressure: receiver holds off while items keep coming
        hold_req = 1'b1;
        random_typing(30, 0, 0);

        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (tracker.reports_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.reports_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
